// ===== rtl/kdo_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kdo_pkg;

  // Fixed constants, Q0.32 unless noted
  localparam logic [28:0] K_RPM      = 29'd449767923;   // 2*pi/60
  localparam logic [31:0] INV_SQRT3  = 32'd2479700525;  // 1/sqrt(3)
  localparam logic [31:0] THIRD      = 32'd1431655765;  // 1/3
  localparam logic [31:0] TWO_THIRDS = 32'd2863311531;  // 2/3
  localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;

  localparam logic [15:0] RADIUS_RESET = 16'd3330;

  // Sine table size, entries per turn as a power of two
  localparam int TABLE_BITS = 10;

  // Displacement divide: microseconds to seconds
  localparam logic [20:0] DIVISOR   = 21'd1000000;
  localparam logic [21:0] DIV_TWICE = 22'd2000000;
  localparam logic [52:0] DIV_HALF  = 53'd500000;
  localparam logic [32:0] RECIP_1E6 = 33'd4503599627;  // floor(2^52 / 10^6)
  localparam int          QUO_BITS  = 34;

  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;

  typedef logic signed [MUL_W-1:0]  mul_op_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // Quarter-wave sine entry i for a table of 2^tb entries per turn,
  // Q30 Taylor series rounded to Q16 (elaboration only)
  function automatic logic [16:0] quarter_sine(input int i, input int tb);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] prod;
    logic signed [63:0] sum;
    logic signed [63:0] e;
    x = ((PI_Q60 >> (tb - 1)) * 64'(i)) >> 30;
    x2 = (x * x) >> 30;
    term = x;
    sum = signed'(x);
    for (int k = 1; k <= 8; k++) begin
      prod = (term * x2) >> 30;
      case (k)
        1: term = prod / 64'd6;
        2: term = prod / 64'd20;
        3: term = prod / 64'd42;
        4: term = prod / 64'd72;
        5: term = prod / 64'd110;
        6: term = prod / 64'd156;
        7: term = prod / 64'd210;
        default: term = prod / 64'd272;
      endcase
      if (k % 2 == 1) sum = sum - signed'(term);
      else sum = sum + signed'(term);
    end
    if (sum < 0) sum = 0;
    e = (sum + 64'sd8192) >>> 14;
    if (e > 64'sd65536) e = 64'sd65536;
    return e[16:0];
  endfunction

  // Round to nearest, ties away from zero, divide by 2^16
  function automatic logic signed [33:0] rnd16(input prod_t a);
    prod_t s;
    s = a + prod_t'(32768) - prod_t'({1'b0, a[PROD_W-1]});
    return s[49:16];
  endfunction

  // Same, divide by 2^32, truncated to 32 bits
  function automatic logic signed [31:0] rnd32(input prod_t a);
    prod_t s;
    s = a + (prod_t'(1) <<< 31) - prod_t'({1'b0, a[PROD_W-1]});
    return s[63:32];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/kdo_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kdo_mul
  import kdo_pkg::*;
(
  input  wire logic    clk,
  input  wire mul_op_t a,
  input  wire mul_op_t b,
  output prod_t        p
);

  // Shared signed multiplier, product registered
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

`default_nettype wire

// ===== rtl/kdo_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kdo_div
  import kdo_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 load,
  input  wire logic                 est,
  input  wire logic                 fin,
  input  wire prod_t                p,
  output mul_op_t                   n_hi,
  output mul_op_t                   q_est,
  output logic signed [QUO_BITS:0]  quo
);

  logic [52:0]         mag;
  logic                neg;
  logic [QUO_BITS-1:0] q0;
  logic [QUO_BITS-1:0] qm;
  prod_t               mag_full;
  logic [21:0]         rem;
  logic [1:0]          adj;

  // |a| + d/2; quotient estimate from the top bits times 2^52/d, which
  // falls at most two short, then fixed up from the remainder
  assign mag_full = p[PROD_W-1] ? -p : p;
  assign n_hi     = mul_op_t'(mag[52:19]);
  assign q_est    = mul_op_t'(q0);

  // Remainder is below 3*d, so the low bits are enough
  assign rem = mag[21:0] - p[21:0];

  always_comb begin
    if (rem >= DIV_TWICE) begin
      adj = 2'd2;
    end else if (rem >= {1'b0, DIVISOR}) begin
      adj = 2'd1;
    end else begin
      adj = 2'd0;
    end
  end

  // load: dividend product; est: estimate product; fin: estimate times d
  always_ff @(posedge clk) begin
    if (load) begin
      mag <= mag_full[52:0] + DIV_HALF;
      neg <= p[PROD_W-1];
    end
    if (est) q0 <= p[66:33];
    if (fin) qm <= q0 + {32'd0, adj};
  end

  assign quo = neg ? -$signed({1'b0, qm}) : $signed({1'b0, qm});

endmodule

`default_nettype wire

// ===== rtl/kdo_sine_rom.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kdo_sine_rom
  import kdo_pkg::*;
#(
  parameter int SINE_TABLE_BITS = TABLE_BITS
) (
  input  wire logic [15:0]  heading,
  output logic signed [17:0] sin_val,
  output logic signed [17:0] cos_val
);

  localparam int TB = SINE_TABLE_BITS;
  localparam int QL = 1 << (TB - 2);

  logic [16:0]   qtab [QL+1];
  logic [TB-1:0] s_idx;
  logic [TB-1:0] c_idx;
  logic [16:0]   s_mag;
  logic [16:0]   c_mag;

  // Quarter-wave constant table
  for (genvar g = 0; g <= QL; g++) begin : g_tab
    assign qtab[g] = quarter_sine(g, TB);
  end

  assign s_idx = heading[15 -: TB];
  assign c_idx = s_idx + TB'(QL);

  // Fold the angle into the first quadrant
  assign s_mag = s_idx[TB-2] ? qtab[(TB-1)'(QL) - (TB-1)'(s_idx[TB-3:0])]
                             : qtab[(TB-1)'(s_idx[TB-3:0])];
  assign c_mag = c_idx[TB-2] ? qtab[(TB-1)'(QL) - (TB-1)'(c_idx[TB-3:0])]
                             : qtab[(TB-1)'(c_idx[TB-3:0])];

  assign sin_val = s_idx[TB-1] ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
  assign cos_val = c_idx[TB-1] ? -$signed({1'b0, c_mag}) : $signed({1'b0, c_mag});

endmodule

`default_nettype wire

// ===== rtl/kiwi_drive_odometry.sv =====
// Dead-reckoning odometry for a three-wheel omni base.
// Input channel (in_valid / in_stall): one request per tick carrying the
// three wheel speeds in rpm, the heading and the elapsed microseconds.
// Output channel (out_valid / out_stall): one result per request with the
// saturated x/y position, the heading, the new body velocity and spin.
// Config channel (cfg_valid / cfg_ready / cfg_data): wheel radius, Q0.16;
// write only while no request is in flight.
// Each request makes 21 passes through the shared multiplier, each an issue
// state and then a take state, with a position state after each divide to
// add the x or y displacement; the done state loads the result register once
// the output is free and goes back to idle. The divide by one million is a
// reciprocal multiply plus a remainder fix-up on the same multiplier. in_stall
// stays high while a request is being worked on. A finished result sits in the
// output register; the next request is taken meanwhile, and it finishes only
// once the previous result has been taken.
// Reset clears the position and the stored velocity, sets the wheel
// radius to 3330 and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module kiwi_drive_odometry
  import kdo_pkg::*;
#(
  parameter int SINE_TABLE_BITS = TABLE_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] left_rpm,
  input  wire logic signed [15:0] right_rpm,
  input  wire logic signed [15:0] back_rpm,
  input  wire logic [15:0]        heading,
  input  wire logic [19:0]        elapsed_us,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [47:0]      pos_x,
  output logic signed [47:0]      pos_y,
  output logic [15:0]             heading_out,
  output logic signed [31:0]      vel_x,
  output logic signed [31:0]      vel_y,
  output logic signed [31:0]      spin_rate,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [15:0]        cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ISSUE = 3'd1;
  localparam logic [2:0] ST_TAKE  = 3'd2;
  localparam logic [2:0] ST_POS   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam logic [4:0] SP_RX0 = 5'd0;
  localparam logic [4:0] SP_RX1 = 5'd1;
  localparam logic [4:0] SP_RY0 = 5'd2;
  localparam logic [4:0] SP_RY1 = 5'd3;
  localparam logic [4:0] SP_DX  = 5'd4;
  localparam logic [4:0] SP_DXR = 5'd5;
  localparam logic [4:0] SP_DXQ = 5'd6;
  localparam logic [4:0] SP_DY  = 5'd7;
  localparam logic [4:0] SP_DYR = 5'd8;
  localparam logic [4:0] SP_DYQ = 5'd9;
  localparam logic [4:0] SP_WL0 = 5'd10;
  localparam logic [4:0] SP_WL1 = 5'd11;
  localparam logic [4:0] SP_WR0 = 5'd12;
  localparam logic [4:0] SP_WR1 = 5'd13;
  localparam logic [4:0] SP_WB0 = 5'd14;
  localparam logic [4:0] SP_WB1 = 5'd15;
  localparam logic [4:0] SP_VX  = 5'd16;
  localparam logic [4:0] SP_VY0 = 5'd17;
  localparam logic [4:0] SP_VY1 = 5'd18;
  localparam logic [4:0] SP_SP0 = 5'd19;
  localparam logic [4:0] SP_SP1 = 5'd20;

  logic [2:0] state;
  logic [4:0] step;

  logic [15:0]        radius;
  logic signed [31:0] body_vel_x;
  logic signed [31:0] body_vel_y;
  logic signed [47:0] position_x;
  logic signed [47:0] position_y;

  logic signed [15:0] l_rpm;
  logic signed [15:0] r_rpm;
  logic signed [15:0] b_rpm;
  logic [15:0]        hdg;
  logic [19:0]        dt;

  prod_t              acc;
  logic signed [33:0] rx;
  logic signed [33:0] ry;
  logic signed [31:0] t_prod;
  logic signed [31:0] vl;
  logic signed [31:0] vr;
  logic signed [31:0] vb;
  logic signed [31:0] vx;
  logic signed [31:0] vy;
  logic signed [31:0] spin;

  mul_op_t            op_a;
  mul_op_t            op_b;
  prod_t              p;
  logic signed [17:0] sin_val;
  logic signed [17:0] cos_val;

  logic               div_load;
  logic               div_est;
  logic               div_fin;
  mul_op_t            n_hi;
  mul_op_t            q_est;
  logic signed [QUO_BITS:0] quo;

  logic signed [47:0] pos_cur;
  logic signed [48:0] pos_sum;
  logic signed [47:0] pos_next;
  logic               in_acc;
  logic               out_free;

  kdo_sine_rom #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_rom (
    .heading (hdg),
    .sin_val (sin_val),
    .cos_val (cos_val)
  );

  kdo_mul u_mul (
    .clk (clk),
    .a   (op_a),
    .b   (op_b),
    .p   (p)
  );

  kdo_div u_div (
    .clk   (clk),
    .load  (div_load),
    .est   (div_est),
    .fin   (div_fin),
    .p     (p),
    .n_hi  (n_hi),
    .q_est (q_est),
    .quo   (quo)
  );

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign div_load  = (state == ST_TAKE) && (step == SP_DX || step == SP_DY);
  assign div_est   = (state == ST_TAKE) && (step == SP_DXR || step == SP_DYR);
  assign div_fin   = (state == ST_TAKE) && (step == SP_DXQ || step == SP_DYQ);

  // Operand select for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step)
      SP_RX0: begin op_a = mul_op_t'(body_vel_x); op_b = mul_op_t'(cos_val); end
      SP_RX1: begin op_a = mul_op_t'(body_vel_y); op_b = mul_op_t'(sin_val); end
      SP_RY0: begin op_a = mul_op_t'(body_vel_x); op_b = mul_op_t'(sin_val); end
      SP_RY1: begin op_a = mul_op_t'(body_vel_y); op_b = mul_op_t'(cos_val); end
      SP_DX:  begin op_a = rx; op_b = mul_op_t'({1'b0, dt}); end
      SP_DY:  begin op_a = ry; op_b = mul_op_t'({1'b0, dt}); end
      SP_DXR, SP_DYR: begin op_a = n_hi; op_b = mul_op_t'({1'b0, RECIP_1E6}); end
      SP_DXQ, SP_DYQ: begin op_a = q_est; op_b = mul_op_t'({1'b0, DIVISOR}); end
      SP_WL0: begin op_a = mul_op_t'(l_rpm); op_b = mul_op_t'({1'b0, radius}); end
      SP_WR0: begin op_a = mul_op_t'(r_rpm); op_b = mul_op_t'({1'b0, radius}); end
      SP_WB0: begin op_a = mul_op_t'(b_rpm); op_b = mul_op_t'({1'b0, radius}); end
      SP_WL1, SP_WR1, SP_WB1: begin
        op_a = mul_op_t'(t_prod);
        op_b = mul_op_t'({1'b0, K_RPM});
      end
      SP_VX: begin
        op_a = mul_op_t'(vl) - mul_op_t'(vr);
        op_b = mul_op_t'({1'b0, INV_SQRT3});
      end
      SP_VY0: begin op_a = mul_op_t'(vb); op_b = mul_op_t'({1'b0, TWO_THIRDS}); end
      SP_SP0: begin op_a = mul_op_t'(vb); op_b = mul_op_t'({1'b0, THIRD}); end
      SP_VY1, SP_SP1: begin
        op_a = mul_op_t'(vl) + mul_op_t'(vr);
        op_b = mul_op_t'({1'b0, INV_SQRT3});
      end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  // Saturating position add
  assign pos_cur = (step == SP_DXQ) ? position_x : position_y;
  assign pos_sum = 49'(pos_cur) + 49'(quo);
  always_comb begin
    if (pos_sum[48] != pos_sum[47]) begin
      pos_next = pos_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      pos_next = pos_sum[47:0];
    end
  end

  // Sequencer and persistent state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= SP_RX0;
      out_valid <= 1'b0;
      radius <= RADIUS_RESET;
      body_vel_x <= '0;
      body_vel_y <= '0;
      position_x <= '0;
      position_y <= '0;
    end else begin
      if (state == ST_DONE && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) radius <= cfg_data;
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            step <= SP_RX0;
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: state <= ST_TAKE;
        ST_TAKE: begin
          if (step == SP_DXQ || step == SP_DYQ) begin
            state <= ST_POS;
          end else if (step == SP_SP1) begin
            state <= ST_DONE;
          end else begin
            step <= step + 1'b1;
            state <= ST_ISSUE;
          end
        end
        ST_POS: begin
          if (step == SP_DXQ) position_x <= pos_next;
          else position_y <= pos_next;
          step <= step + 1'b1;
          state <= ST_ISSUE;
        end
        ST_DONE: begin
          if (out_free) begin
            body_vel_x <= vx;
            body_vel_y <= vy;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Request capture, product handling and result register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      l_rpm <= left_rpm;
      r_rpm <= right_rpm;
      b_rpm <= back_rpm;
      hdg <= heading;
      dt <= elapsed_us;
    end
    if (state == ST_TAKE) begin
      case (step)
        SP_RX0, SP_RY0, SP_VY0, SP_SP0: acc <= p;
        SP_RX1: rx <= rnd16(acc - p);
        SP_RY1: ry <= rnd16(acc + p);
        SP_WL0, SP_WR0, SP_WB0: t_prod <= p[31:0];
        SP_WL1: vl <= rnd32(p);
        SP_WR1: vr <= rnd32(p);
        SP_WB1: vb <= rnd32(p);
        SP_VX:  vx <= rnd32(p);
        SP_VY1: vy <= rnd32(acc - p);
        SP_SP1: spin <= rnd32(acc + p);
        default: acc <= acc;
      endcase
    end
    if (state == ST_DONE && out_free) begin
      pos_x <= position_x;
      pos_y <= position_y;
      heading_out <= hdg;
      vel_x <= vx;
      vel_y <= vy;
      spin_rate <= spin;
    end
  end

  // Checks
  a_pos_from_take: assert property (@(posedge clk) disable iff (rst)
    state == ST_POS |-> $past(state) == ST_TAKE)
    else $error("position add not preceded by a multiplier take");

  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    state == ST_POS |-> (step == SP_DXQ || step == SP_DYQ))
    else $error("position add on a non-displacement step");

  a_vel_update: assert property (@(posedge clk) disable iff (rst)
    !$stable(body_vel_x) |-> $past(state) == ST_DONE)
    else $error("body velocity changed outside result load");

  a_out_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE && state == ST_IDLE)
    else $error("result presented without finishing a request");

endmodule

`default_nettype wire

// ===== tb/kiwi_drive_odometry_test.sv =====
`timescale 1ns / 1ps

typedef struct {
  logic signed [47:0] px;
  logic signed [47:0] py;
  logic [15:0]        hd;
  logic signed [31:0] vx;
  logic signed [31:0] vy;
  logic signed [31:0] spin;
} odo_result_t;

// Odometry predictor plus queue of pending position/velocity results
class odo_scoreboard;
  localparam int TBL_BITS = 10;
  localparam int QLEN = 1 << (TBL_BITS - 2);
  localparam longint RPM_GAIN = 449767923;
  localparam longint INV_ROOT3 = 64'd2479700525;
  localparam longint ONE_THIRD = 1431655765;
  localparam longint TWO_THIRD = 64'd2863311531;
  localparam longint POS_HI = 64'sd140737488355327;
  localparam longint POS_LO = -64'sd140737488355328;

  int sine_q[QLEN + 1];
  longint radius;
  int body_vx, body_vy;
  longint acc_x, acc_y;
  odo_result_t pending_q[$];
  int errors;

  function new();
    longint unsigned pi_q60, x, x2, term;
    longint sum, e;
    pi_q60 = 64'h3243F6A8885A308D;
    for (int i = 0; i <= QLEN; i++) begin
      x = ((pi_q60 >> (TBL_BITS - 1)) * longint'(i)) >> 30;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (int k = 1; k <= 8; k++) begin
        term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      if (sum < 0) sum = 0;
      e = (sum + 8192) >>> 14;
      if (e > 65536) e = 65536;
      sine_q[i] = int'(e);
    end
    radius = 3330;
    body_vx = 0;
    body_vy = 0;
    acc_x = 0;
    acc_y = 0;
    errors = 0;
  endfunction

  // round to nearest, ties away from zero
  function longint round_div(longint a, longint d);
    if (a >= 0) return (a + d / 2) / d;
    return -((-a + d / 2) / d);
  endfunction

  function longint sine_of(int idx);
    int q, r;
    q = (idx & ((1 << TBL_BITS) - 1)) >> (TBL_BITS - 2);
    r = idx & (QLEN - 1);
    case (q)
      0: return sine_q[r];
      1: return sine_q[QLEN - r];
      2: return -sine_q[r];
      default: return -sine_q[QLEN - r];
    endcase
  endfunction

  function longint wheel_mps(logic signed [15:0] rpm);
    longint p;
    p = longint'(rpm) * radius * RPM_GAIN;
    return round_div(p, 64'sd1 <<< 32);
  endfunction

  function longint clamp_pos(longint v);
    if (v > POS_HI) return POS_HI;
    if (v < POS_LO) return POS_LO;
    return v;
  endfunction

  function void note_request(logic signed [15:0] l, logic signed [15:0] r,
                             logic signed [15:0] b, logic [15:0] hd, logic [19:0] dt);
    odo_result_t res;
    int idx;
    longint s, c, rx, ry, vl, vr, vb, vx, vy, sp;
    idx = int'(hd >> (16 - TBL_BITS));
    s = sine_of(idx);
    c = sine_of(idx + QLEN);
    rx = round_div(longint'(body_vx) * c - longint'(body_vy) * s, 65536);
    ry = round_div(longint'(body_vx) * s + longint'(body_vy) * c, 65536);
    acc_x = clamp_pos(acc_x + round_div(rx * longint'(dt), 1000000));
    acc_y = clamp_pos(acc_y + round_div(ry * longint'(dt), 1000000));
    vl = wheel_mps(l);
    vr = wheel_mps(r);
    vb = wheel_mps(b);
    vx = round_div((vl - vr) * INV_ROOT3, 64'sd1 <<< 32);
    vy = round_div(vb * TWO_THIRD - (vl + vr) * INV_ROOT3, 64'sd1 <<< 32);
    sp = round_div(vb * ONE_THIRD + (vl + vr) * INV_ROOT3, 64'sd1 <<< 32);
    body_vx = int'(vx);
    body_vy = int'(vy);
    res.px = acc_x[47:0];
    res.py = acc_y[47:0];
    res.hd = hd;
    res.vx = vx[31:0];
    res.vy = vy[31:0];
    res.spin = sp[31:0];
    pending_q.push_back(res);
  endfunction

  function void check_field(string name, longint e, longint a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
      errors++;
    end
  endfunction

  function void check_result(odo_result_t got);
    odo_result_t want;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual pos_x %0d", $time, got.px);
      errors++;
      return;
    end
    want = pending_q.pop_front();
    check_field("pos_x", want.px, got.px);
    check_field("pos_y", want.py, got.py);
    check_field("heading_out", want.hd, got.hd);
    check_field("vel_x", want.vx, got.vx);
    check_field("vel_y", want.vy, got.vy);
    check_field("spin_rate", want.spin, got.spin);
  endfunction
endclass

module kiwi_drive_odometry_test;
  logic clk, rst;
  logic in_valid, in_stall;
  logic signed [15:0] left_rpm, right_rpm, back_rpm;
  logic [15:0] heading;
  logic [19:0] elapsed_us;
  logic out_valid, out_stall;
  logic signed [47:0] pos_x, pos_y;
  logic [15:0] heading_out;
  logic signed [31:0] vel_x, vel_y, spin_rate;
  logic cfg_valid, cfg_ready;
  logic [15:0] cfg_data;

  odo_scoreboard odo_sb;
  bit no_idle;
  int hold_cycles;
  longint cycle_count;

  kiwi_drive_odometry dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .left_rpm(left_rpm), .right_rpm(right_rpm), .back_rpm(back_rpm),
    .heading(heading), .elapsed_us(elapsed_us),
    .out_valid(out_valid), .out_stall(out_stall),
    .pos_x(pos_x), .pos_y(pos_y), .heading_out(heading_out),
    .vel_x(vel_x), .vel_y(vel_y), .spin_rate(spin_rate),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // monitors: note accepted requests, check accepted results
  always @(posedge clk) begin
    odo_result_t got;
    if (!rst) begin
      if (in_valid && !in_stall)
        odo_sb.note_request(left_rpm, right_rpm, back_rpm, heading, elapsed_us);
      if (out_valid && !out_stall) begin
        got.px = pos_x;
        got.py = pos_y;
        got.hd = heading_out;
        got.vx = vel_x;
        got.vy = vel_y;
        got.spin = spin_rate;
        odo_sb.check_result(got);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stall bursts, long hold on request, none when no_idle is set
  initial begin
    int run_left;
    bit stall_now;
    run_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else if (no_idle) begin
        out_stall <= 1'b0;
      end else begin
        if (run_left == 0) begin
          stall_now = ($urandom_range(0, 2) == 0);
          run_left = stall_now ? $urandom_range(1, 15) : $urandom_range(1, 40);
          out_stall <= stall_now;
        end
        run_left--;
      end
    end
  end

  task automatic send_request(logic signed [15:0] l, logic signed [15:0] r,
                              logic signed [15:0] b, logic [15:0] hd, logic [19:0] dt);
    in_valid <= 1'b1;
    left_rpm <= l;
    right_rpm <= r;
    back_rpm <= b;
    heading <= hd;
    elapsed_us <= dt;
    do @(posedge clk); while (in_stall);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic send_random();
    logic signed [15:0] l, r, b;
    logic [19:0] dt;
    l = 16'($urandom);
    r = 16'($urandom);
    b = 16'($urandom);
    // mostly modest speeds and control-loop periods
    if ($urandom_range(0, 2) != 0) begin
      l = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
      r = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
      b = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
    end
    dt = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 20000));
    send_request(l, r, b, 16'($urandom), dt);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (odo_sb.pending_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_radius(logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    odo_sb.radius = longint'(value);
  endtask

  initial begin
    odo_sb = new();
    no_idle = 0;
    hold_cycles = 0;
    cycle_count = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    left_rpm = '0;
    right_rpm = '0;
    back_rpm = '0;
    heading = '0;
    elapsed_us = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: first tick after reset, extremes, every quadrant, zero time
    send_request(16'sd32767, -16'sd32768, 16'sd0, 16'h0000, 20'd1000);
    send_request(-16'sd32768, 16'sd32767, 16'sd32767, 16'h0000, 20'hFFFFF);
    send_request(16'sd0, 16'sd0, -16'sd32768, 16'h4000, 20'hFFFFF);
    send_request(16'sd1000, 16'sd1000, 16'sd1000, 16'h8000, 20'hFFFFF);
    send_request(-16'sd1, 16'sd1, -16'sd1, 16'hC000, 20'd0);
    send_request(16'sd500, -16'sd300, 16'sd200, 16'hFFFF, 20'd10000);
    send_request(16'sd0, 16'sd0, 16'sd0, 16'h3FFF, 20'd10000);
    send_request(-16'sd32768, -16'sd32768, -16'sd32768, 16'h2000, 20'd0);
    send_request(16'sd32767, 16'sd32767, 16'sd32767, 16'hBFFF, 20'hFFFFF);
    send_request(16'sd1, -16'sd1, 16'sd0, 16'h7FFF, 20'd1);
    send_request(16'sd1200, 16'sd0, -16'sd1200, 16'h0040, 20'd5000);
    send_request(16'sd0, 16'sd0, 16'sd0, 16'h5555, 20'd999999);
    send_request(16'sd32767, -16'sd32768, 16'sd32767, 16'hAAAA, 20'd1000000);
    wait_drained();

    // widest radius, long output hold so the block backs up
    write_radius(16'hFFFF);
    hold_cycles = 600;
    repeat (160) send_random();
    wait_drained();

    // zero radius: velocity collapses to zero
    write_radius(16'h0000);
    repeat (150) send_random();
    wait_drained();

    // random radius; sender pauses mid-phase until all results are back
    write_radius(16'($urandom));
    repeat (80) send_random();
    wait_drained();
    repeat (80) send_random();
    wait_drained();

    write_radius(16'($urandom));
    repeat (200) send_random();
    wait_drained();

    // back to nominal radius, no idling on either side
    write_radius(16'd3330);
    no_idle = 1;
    repeat (220) send_random();
    wait_drained();

    if (odo_sb.errors == 0 && odo_sb.pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
